>>> hw/rtl/vrra_pkg.sv
// Shared types and constants for the variable record ring allocator.
// Holds the controller state type and the controller/datapath command and status bundles.
// No dependencies.
`timescale 1ns / 1ps

package vrra_pkg;

  // Width of the record length input field
  localparam int IN_LEN_W = 7;
  // Width used to compare the raw length against the maximum record size
  localparam int LEN_CMP_W = 8;

  typedef enum logic [2:0] {
    ST_CLEAR,   // post-reset pass that zeroes the length store
    ST_IDLE,    // waiting for a record length
    ST_TAIL,    // zeroing the unused tail before a wrap
    ST_WALK,    // test the oldest pointer against the new record span
    ST_WAIT,    // store read in flight, advance the oldest pointer
    ST_COMMIT,  // write the new length, update the oldest pointer
    ST_DONE     // hand the result to the output register
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic sweep_wr;
    logic load;
    logic rd;
    logic walk_step;
    logic commit;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic tail_needed;
    logic in_range;
    logic out_free;
  } sts_t;

endpackage

>>> hw/rtl/vrra_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module vrra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/vrra_ctrl.sv
// Controller state machine for the variable record ring allocator.
// Depends on vrra_pkg for the state type and the command/status bundles.
`timescale 1ns / 1ps

module vrra_ctrl import vrra_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (sts.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_next = sts.tail_needed ? ST_TAIL : ST_WALK;
      end
      ST_TAIL: begin
        if (sts.sweep_last) state_next = ST_WALK;
      end
      ST_WALK: begin
        state_next = sts.in_range ? ST_WAIT : ST_COMMIT;
      end
      ST_WAIT: begin
        state_next = ST_WALK;
      end
      ST_COMMIT: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_CLEAR: begin
        cmd.sweep_wr = 1'b1;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      ST_TAIL: begin
        cmd.sweep_wr = 1'b1;
      end
      ST_WALK: begin
        cmd.rd = sts.in_range;
      end
      ST_WAIT: begin
        cmd.walk_step = 1'b1;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
      end
      ST_DONE: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

`ifndef SYNTHESIS
  // A load only happens on an input transfer
  a_load_on_transfer: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (in_valid && !in_stall))
    else $error("load without input transfer");

  // Every store read is followed by a pointer update
  a_rd_then_step: assert property (@(posedge clk) disable iff (rst)
    cmd.rd |=> cmd.walk_step)
    else $error("store read not consumed");

  // Commit is always followed by the result handoff stage
  a_commit_then_done: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (state == ST_DONE))
    else $error("commit not followed by result stage");
`endif

endmodule

>>> hw/rtl/vrra_datapath.sv
// Datapath for the variable record ring allocator: pointers, walk register,
// length store and output register. Depends on vrra_pkg and vrra_ram.
`timescale 1ns / 1ps

module vrra_datapath import vrra_pkg::*; #(
  parameter int BUF_BYTES  = 4096,
  parameter int MAX_RECORD = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [IN_LEN_W-1:0]          record_length,
  input  cmd_t                         cmd,
  output sts_t                         sts,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [$clog2(BUF_BYTES)-1:0] write_offset,
  output logic [$clog2(BUF_BYTES)-1:0] oldest_offset,
  output logic                         wrapped
);

  localparam int AW = $clog2(BUF_BYTES);
  localparam int PW = $clog2(BUF_BYTES + 1);
  localparam int LW = $clog2(MAX_RECORD + 1);
  localparam int WW = $clog2(BUF_BYTES + MAX_RECORD);

  localparam logic [PW-1:0]        BUF_P  = PW'(BUF_BYTES);
  localparam logic [WW-1:0]        BUF_W  = WW'(BUF_BYTES);
  localparam logic [AW-1:0]        LAST_A = AW'(BUF_BYTES - 1);
  localparam logic [LEN_CMP_W-1:0] MAX_C  = LEN_CMP_W'(MAX_RECORD);

  // Allocation state
  logic [PW-1:0] next_free;
  logic [AW-1:0] oldest;
  logic [AW-1:0] sweep_addr;

  // Per-item working registers
  logic [AW-1:0] pos;
  logic [PW-1:0] end_pos;
  logic [LW-1:0] len;
  logic          wrap_flag;
  logic [WW-1:0] walk;
  logic          walk_stop;

  // Combinational
  logic [LEN_CMP_W-1:0] raw_len;
  logic [LW-1:0]        len_sat;
  logic [PW-1:0]        room;
  logic                 wrap_in;
  logic [AW-1:0]        pos_in;
  logic                 in_range;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [LW-1:0]        ram_wdata;
  logic [LW-1:0]        ram_rdata;

  // Length clamp: zero counts as one, oversize saturates
  assign raw_len = LEN_CMP_W'(record_length);
  always_comb begin
    priority if (raw_len == '0) begin
      len_sat = LW'(1);
    end else if (raw_len > MAX_C) begin
      len_sat = LW'(MAX_RECORD);
    end else begin
      len_sat = LW'(raw_len);
    end
  end

  // Placement: wrap to zero when the tail is too short
  assign room    = BUF_P - next_free;
  assign wrap_in = WW'(room) < WW'(len_sat);
  assign pos_in  = wrap_in ? '0 : next_free[AW-1:0];

  // Oldest pointer lies inside the new record span
  assign in_range = !walk_stop && (walk >= WW'(pos)) && (walk < WW'(end_pos));

  // Status to controller
  always_comb begin
    sts.sweep_last  = (sweep_addr == LAST_A);
    sts.tail_needed = wrap_in && (next_free != BUF_P);
    sts.in_range    = in_range;
    sts.out_free    = !out_valid || !out_stall;
  end

  // Store write port: sweeps write zero, commit writes the new length
  assign ram_we    = cmd.sweep_wr || cmd.commit;
  assign ram_waddr = cmd.commit ? pos : sweep_addr;
  assign ram_wdata = cmd.commit ? len : '0;

  vrra_ram #(
    .WIDTH (LW),
    .DEPTH (BUF_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (walk[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Allocation state and sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      next_free  <= '0;
      oldest     <= '0;
      sweep_addr <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.sweep_wr) begin
        sweep_addr <= sts.sweep_last ? '0 : sweep_addr + AW'(1);
      end else if (cmd.load) begin
        sweep_addr <= next_free[AW-1:0];
      end
      if (cmd.load) begin
        next_free <= PW'(WW'(pos_in) + WW'(len_sat));
      end
      if (cmd.commit) begin
        oldest <= (walk >= BUF_W) ? '0 : walk[AW-1:0];
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Per-item registers and walk
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos       <= pos_in;
      end_pos   <= PW'(WW'(pos_in) + WW'(len_sat));
      len       <= len_sat;
      wrap_flag <= wrap_in;
      walk      <= wrap_in ? '0 : WW'(oldest);
      walk_stop <= 1'b0;
    end else if (cmd.walk_step) begin
      if (ram_rdata == '0) begin
        walk      <= '0;
        walk_stop <= 1'b1;
      end else begin
        walk <= walk + WW'(ram_rdata);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      write_offset  <= pos;
      oldest_offset <= oldest;
      wrapped       <= wrap_flag;
    end
  end

`ifndef SYNTHESIS
  // Free position never runs past the buffer end
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    next_free <= BUF_P)
    else $error("free position beyond buffer end");

  // A walk read always addresses inside the buffer
  a_walk_addr: assert property (@(posedge clk) disable iff (rst)
    in_range |-> (walk < BUF_W))
    else $error("walk address out of buffer");

  // New record span is non-empty and fits the buffer
  a_span: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> ((WW'(end_pos) > WW'(pos)) && (end_pos <= BUF_P)))
    else $error("bad record span");
`endif

endmodule

>>> hw/rtl/variable_record_ring_allocator.sv
// Top level of the variable record ring allocator.
// Depends on vrra_pkg, vrra_ctrl, vrra_datapath (which holds vrra_ram).
//
// Allocates byte offsets for variable-length records in a circular trace
// buffer of BUF_BYTES bytes that overwrites its oldest records.
// Input channel: record_length with in_valid/in_stall; one transfer per record.
// Output channel: write_offset, oldest_offset and wrapped with
// out_valid/out_stall; exactly one result per input record, in order.
// Records that do not fit before the buffer end go to offset 0 (wrapped=1)
// after the unused tail of the length store is zeroed, one entry per cycle.
// The oldest pointer then walks past every overlapped record, one store read
// per record.
// After an input transfer the controller sweeps the tail on a wrap (fewer
// than MAX_RECORD entries), walks the overlapped records, commits the new
// length and hands the result to the output register.
// One record is in flight at a time; in_stall is high while it is worked on.
// The output register holds a result while out_stall is high; the next input
// can be taken meanwhile, but its result waits for the register to free up.
// After reset the length store is cleared in a pass over all BUF_BYTES entries,
// during which in_stall stays high.
`timescale 1ns / 1ps

module variable_record_ring_allocator import vrra_pkg::*; #(
  parameter int BUF_BYTES  = 4096,
  parameter int MAX_RECORD = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [IN_LEN_W-1:0]          record_length,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [$clog2(BUF_BYTES)-1:0] write_offset,
  output logic [$clog2(BUF_BYTES)-1:0] oldest_offset,
  output logic                         wrapped
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  vrra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Pointers, store and output register
  vrra_datapath #(
    .BUF_BYTES  (BUF_BYTES),
    .MAX_RECORD (MAX_RECORD)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .record_length (record_length),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .write_offset  (write_offset),
    .oldest_offset (oldest_offset),
    .wrapped       (wrapped)
  );

endmodule
